[src/afd_pkg.sv]
`timescale 1ns / 1ps

package afd_pkg;

   localparam logic [7:0] HEADER_BYTE        = 8'hAA;
   localparam logic [7:0] WILDCARD           = 8'hFF;
   localparam logic [7:0] RESET_MATCH_ADDR   = 8'hFF;
   localparam logic [7:0] RESET_MATCH_FUNC   = 8'hFF;
   localparam logic [7:0] RESET_MAX_ATTEMPTS = 8'd32;
   localparam logic [7:0] COUNT_LIMIT        = 8'hFF;

   typedef enum logic [1:0] {
      CSR_MATCH_ADDRESS  = 2'd0,
      CSR_MATCH_FUNCTION = 2'd1,
      CSR_MAX_ATTEMPTS   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_ADDRESS  = 3'd1,
      PH_FUNCTION = 3'd2,
      PH_LENGTH   = 3'd3,
      PH_PAYLOAD  = 3'd4,
      PH_CHECK    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_OK     = 2'd1,
      KIND_BAD    = 2'd2,
      KIND_GIVEUP = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] match_address;
      logic [7:0] match_function;
      logic [7:0] max_attempts;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [7:0] frame_length;
      logic [7:0] frame_address;
      logic [7:0] frame_function;
   } result_type;

endpackage

[src/addressed_frame_deframer_unit.sv]
`timescale 1ns / 1ps

// addressed frame deframer
// req channel: one received byte per transaction (req_rx_byte), req_valid / req_stall
// rsp channel: payload bytes and frame status (accepted, checksum failed, give-up),
//    rsp_valid / rsp_stall; bytes that end a frame silently give no transaction
// csr channel: csr_valid / csr_ready with csr_index 0 match address, 1 match function,
//    2 max attempts; csr_ready is always high, write only while idle
// order: an accepted byte is held in the input register, parsed there, and its result is loaded
//    into the rsp register, which drives rsp_valid
// throughput: one byte per cycle unless rsp_stall holds a full result register; the parser
//    step between the input register and the result register is combinational
// stall: a full result register held by rsp_stall stops the parser, and the input
//    register then raises req_stall; no transaction is lost or repeated
// reset: parser waits for a header, counters clear, match values return to 0xff
//    (wildcard) and max attempts to 32

module addressed_frame_deframer_unit import afd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_index,
   output logic [7:0] rsp_frame_length,
   output logic [7:0] rsp_frame_address,
   output logic [7:0] rsp_frame_function,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   cfg_type    cfg;
   logic       out_ready;
   logic       res_valid;
   result_type res;
   result_type rsp;

   afd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   afd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .out_ready   (out_ready),
      .res_valid   (res_valid),
      .res         (res)
   );

   afd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_kind           = rsp.kind;
   assign rsp_data_byte      = rsp.data_byte;
   assign rsp_byte_index     = rsp.byte_index;
   assign rsp_frame_length   = rsp.frame_length;
   assign rsp_frame_address  = rsp.frame_address;
   assign rsp_frame_function = rsp.frame_function;

endmodule

[src/afd_csr.sv]
`timescale 1ns / 1ps

module afd_csr import afd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MATCH_ADDRESS:  cfg_in.match_address  = csr_data;
            CSR_MATCH_FUNCTION: cfg_in.match_function = csr_data;
            CSR_MAX_ATTEMPTS:   cfg_in.max_attempts   = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_address  <= RESET_MATCH_ADDR;
         cfg_ff.match_function <= RESET_MATCH_FUNC;
         cfg_ff.max_attempts   <= RESET_MAX_ATTEMPTS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/afd_parser.sv]
`timescale 1ns / 1ps

module afd_parser import afd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       out_ready,
   output logic       res_valid,
   output result_type res
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   phase_type  phase_ff, phase_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] address_ff, address_in;
   logic [7:0] function_ff, function_in;
   logic [7:0] fails_ff, fails_in;

   logic       advance;
   logic       accept;
   logic [7:0] fails_inc;
   logic       give_up;
   logic [7:0] count_inc;
   logic [7:0] sum_add;
   logic       produce;

   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign fails_inc = (fails_ff == COUNT_LIMIT) ? fails_ff : fails_ff + 8'd1;
   assign give_up   = fails_inc >= cfg.max_attempts;
   assign count_inc = count_ff + 8'd1;
   assign sum_add   = sum_ff + in_byte_ff;

   always_comb begin
      phase_in    = phase_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      address_in  = address_ff;
      function_in = function_ff;
      fails_in    = fails_ff;
      produce     = 1'b0;
      res         = '{kind: KIND_DATA, data_byte: 8'd0, byte_index: 8'd0,
                      frame_length: length_ff, frame_address: address_ff,
                      frame_function: function_ff};
      if (advance) begin
         case (phase_ff)
            PH_HEADER: begin
               if (in_byte_ff != HEADER_BYTE) begin
                  phase_in = PH_HEADER;
                  fails_in = give_up ? 8'd0 : fails_inc;
                  produce  = give_up;
               end else begin
                  sum_in      = in_byte_ff;
                  count_in    = 8'd0;
                  length_in   = 8'd0;
                  address_in  = 8'd0;
                  function_in = 8'd0;
                  phase_in    = PH_ADDRESS;
               end
            end
            PH_ADDRESS: begin
               if (in_byte_ff != cfg.match_address && cfg.match_address != WILDCARD) begin
                  phase_in = PH_HEADER;
                  fails_in = give_up ? 8'd0 : fails_inc;
                  produce  = give_up;
               end else begin
                  address_in = in_byte_ff;
                  sum_in     = sum_add;
                  phase_in   = PH_FUNCTION;
               end
            end
            PH_FUNCTION: begin
               if (in_byte_ff != cfg.match_function && cfg.match_function != WILDCARD) begin
                  phase_in = PH_HEADER;
                  fails_in = give_up ? 8'd0 : fails_inc;
                  produce  = give_up;
               end else begin
                  function_in = in_byte_ff;
                  sum_in      = sum_add;
                  phase_in    = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               length_in = in_byte_ff;
               sum_in    = sum_add;
               count_in  = 8'd0;
               phase_in  = (in_byte_ff == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               sum_in         = sum_add;
               produce        = 1'b1;
               res.kind       = KIND_DATA;
               res.data_byte  = in_byte_ff;
               res.byte_index = count_ff;
               count_in       = count_inc;
               if (count_inc >= length_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               phase_in = PH_HEADER;
               produce  = 1'b1;
               if (in_byte_ff == sum_ff) begin
                  fails_in = 8'd0;
                  res.kind = KIND_OK;
               end else begin
                  fails_in = give_up ? 8'd0 : fails_inc;
                  res.kind = KIND_BAD;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
         if (produce && (phase_ff != PH_PAYLOAD) && give_up &&
             !(phase_ff == PH_CHECK && in_byte_ff == sum_ff)) begin
            res = '{kind: KIND_GIVEUP, data_byte: 8'd0, byte_index: 8'd0,
                    frame_length: 8'd0, frame_address: 8'd0, frame_function: 8'd0};
         end
      end
   end

   assign res_valid = produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_HEADER;
         sum_ff      <= 8'd0;
         count_ff    <= 8'd0;
         length_ff   <= 8'd0;
         address_ff  <= 8'd0;
         function_ff <= 8'd0;
         fails_ff    <= 8'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         length_ff   <= length_in;
         address_ff  <= address_in;
         function_ff <= function_in;
         fails_ff    <= fails_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   a_ok_clears_fails: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_OK) |=> (fails_ff == 8'd0))
      else $error("accepted frame did not clear failure count");

   a_giveup_clears_fails: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_GIVEUP) |=> (fails_ff == 8'd0 && phase_ff == PH_HEADER))
      else $error("give-up did not restart counting");

   a_data_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_DATA) |-> (phase_ff == PH_PAYLOAD))
      else $error("payload result outside payload phase");

   a_no_work_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !out_ready |-> !res_valid)
      else $error("result produced while output register full");

endmodule

[src/afd_rsp_reg.sv]
`timescale 1ns / 1ps

module afd_rsp_reg import afd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       res_valid,
   input  result_type res,
   output logic       out_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (out_ready) begin
         valid_in = res_valid;
         if (res_valid) begin
            data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule
